/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the sorted table.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Condition must never be seen outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`endif

/* rtl/stir_pkg.sv */
// Package of the sorted table: default sizes, operation and status codes.
// No dependencies.
package stir_pkg;

  localparam int unsigned StirCapacity   = 16;
  localparam int unsigned StirValueWidth = 32;

  typedef enum logic [1:0] {
    KindInsert = 2'd0,
    KindRemove = 2'd1,
    KindClear  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusEmpty    = 2'd1,
    StatusNotFound = 2'd2,
    StatusFull     = 2'd3
  } status_e;

endpackage

/* rtl/stir_chan_if.sv */
// Valid/ready channels of the sorted table: request and response words.
// Depends on stir_pkg.
interface stir_req_if #(
  parameter int unsigned VALUE_WIDTH = stir_pkg::StirValueWidth
);
  import stir_pkg::*;

  logic                          valid;
  logic                          ready;
  logic [1:0]                    kind;
  logic signed [VALUE_WIDTH-1:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

interface stir_rsp_if #(
  parameter int unsigned CAPACITY = stir_pkg::StirCapacity
);
  import stir_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic            valid;
  logic            ready;
  status_e         status;
  logic [CntW-1:0] entry_count;
  logic            is_empty;

  modport source (output valid, output status, output entry_count, output is_empty,
                  input ready);
  modport sink   (input valid, input status, input entry_count, input is_empty,
                  output ready);
endinterface

/* rtl/sorted_table_insert_remove.sv */
// Sorted table of signed values with insert, remove-first-equal and clear.
// Depends on stir_pkg, stir_req_if, stir_rsp_if and assert_macros.svh.
//
//  channel | dir | word                          | handshake
//  --------+-----+-------------------------------+-------------
//  req_i   | in  | kind, value                   | valid/ready
//  rsp_o   | out | status, entry_count, is_empty | valid/ready
//
// One operation at a time; entries live in a single-port-read, single-port-write
// memory with registered read data, walked one entry per cycle.
// Insert moves the entries at or above the value up one, walking down from the last;
// remove moves those after the first equal entry down; clear, full, empty skip the walk.
// The next word is taken once the result is queued.
// Reset clears the count and the result register; the memory needs no clearing.
// A stalled result is held in the output register while the next word is worked.
module sorted_table_insert_remove #(
  parameter int unsigned CAPACITY    = stir_pkg::StirCapacity,
  parameter int unsigned VALUE_WIDTH = stir_pkg::StirValueWidth
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  stir_req_if.sink   req_i,
  stir_rsp_if.source rsp_o
);
  import stir_pkg::*;

  `include "assert_macros.svh"

  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    StIdle,
    StInsScan,
    StInsHead,
    StRemFind,
    StRemShift,
    StResp
  } state_e;

  state_e                        state_q, state_d;
  logic signed [VALUE_WIDTH-1:0] key_q, key_d;
  logic [CntW-1:0]               cnt_q, cnt_d;
  logic [CntW-1:0]               n_q, n_d;
  logic [IdxW-1:0]               idx_q, idx_d;
  status_e                       status_q, status_d;
  logic                          rsp_valid_q, rsp_valid_d;
  status_e                       rsp_status_q, rsp_status_d;
  logic [CntW-1:0]               rsp_count_q, rsp_count_d;

  logic signed [VALUE_WIDTH-1:0] mem_q [CAPACITY];
  logic signed [VALUE_WIDTH-1:0] rd_data_q;
  logic                          rd_en, wr_en;
  logic [IdxW-1:0]               rd_addr, wr_addr;
  logic signed [VALUE_WIDTH-1:0] wr_data;
  logic [IdxW-1:0]               last_idx;

  assign last_idx = IdxW'(n_q - CntW'(1));

  always_comb begin
    state_d      = state_q;
    key_d        = key_q;
    cnt_d        = cnt_q;
    n_d          = n_q;
    idx_d        = idx_q;
    status_d     = status_q;
    rsp_valid_d  = rsp_valid_q;
    rsp_status_d = rsp_status_q;
    rsp_count_d  = rsp_count_q;
    rd_en        = 1'b0;
    rd_addr      = idx_q;
    wr_en        = 1'b0;
    wr_addr      = idx_q;
    wr_data      = key_q;

    if (rsp_valid_q && rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (req_i.valid) begin
          key_d    = req_i.value;
          n_d      = cnt_q;
          status_d = StatusOk;
          state_d  = StResp;
          case (req_i.kind)
            KindInsert: begin
              if (cnt_q >= CntW'(CAPACITY)) begin
                status_d = StatusFull;
              end else if (cnt_q == '0) begin
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_data = req_i.value;
                n_d     = cnt_q + CntW'(1);
              end else begin
                rd_en   = 1'b1;
                rd_addr = IdxW'(cnt_q - CntW'(1));
                idx_d   = IdxW'(cnt_q - CntW'(1));
                state_d = StInsScan;
              end
            end
            KindRemove: begin
              if (cnt_q == '0) begin
                status_d = StatusEmpty;
              end else begin
                rd_en   = 1'b1;
                rd_addr = '0;
                idx_d   = '0;
                state_d = StRemFind;
              end
            end
            KindClear: begin
              n_d = '0;
            end
            default: ;
          endcase
        end
      end
      StInsScan: begin
        wr_en   = 1'b1;
        wr_addr = idx_q + IdxW'(1);
        if (rd_data_q >= key_q) begin
          wr_data = rd_data_q;
          if (idx_q == '0) begin
            state_d = StInsHead;
          end else begin
            rd_en   = 1'b1;
            rd_addr = idx_q - IdxW'(1);
            idx_d   = idx_q - IdxW'(1);
          end
        end else begin
          wr_data = key_q;
          n_d     = n_q + CntW'(1);
          state_d = StResp;
        end
      end
      StInsHead: begin
        wr_en   = 1'b1;
        wr_addr = '0;
        wr_data = key_q;
        n_d     = n_q + CntW'(1);
        state_d = StResp;
      end
      StRemFind: begin
        if (idx_q == last_idx) begin
          if (rd_data_q == key_q) begin
            n_d = n_q - CntW'(1);
          end else begin
            status_d = StatusNotFound;
          end
          state_d = StResp;
        end else begin
          rd_en   = 1'b1;
          rd_addr = idx_q + IdxW'(1);
          idx_d   = idx_q + IdxW'(1);
          if (rd_data_q == key_q) begin
            state_d = StRemShift;
          end
        end
      end
      StRemShift: begin
        wr_en   = 1'b1;
        wr_addr = idx_q - IdxW'(1);
        wr_data = rd_data_q;
        if (idx_q == last_idx) begin
          n_d     = n_q - CntW'(1);
          state_d = StResp;
        end else begin
          rd_en   = 1'b1;
          rd_addr = idx_q + IdxW'(1);
          idx_d   = idx_q + IdxW'(1);
        end
      end
      StResp: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_valid_d  = 1'b1;
          rsp_status_d = status_q;
          rsp_count_d  = n_q;
          cnt_d        = n_q;
          state_d      = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      key_q        <= '0;
      cnt_q        <= '0;
      n_q          <= '0;
      idx_q        <= '0;
      status_q     <= StatusOk;
      rsp_valid_q  <= 1'b0;
      rsp_status_q <= StatusOk;
      rsp_count_q  <= '0;
    end else begin
      state_q      <= state_d;
      key_q        <= key_d;
      cnt_q        <= cnt_d;
      n_q          <= n_d;
      idx_q        <= idx_d;
      status_q     <= status_d;
      rsp_valid_q  <= rsp_valid_d;
      rsp_status_q <= rsp_status_d;
      rsp_count_q  <= rsp_count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  assign req_i.ready       = (state_q == StIdle);
  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.status      = rsp_status_q;
  assign rsp_o.entry_count = rsp_count_q;
  assign rsp_o.is_empty    = (rsp_count_q == '0);

  `ASSERT_NEVER(a_count_bound, clk_i, rst_ni, cnt_q > CntW'(CAPACITY))
  `ASSERT_PROP(a_full_count, clk_i, rst_ni,
               (state_q == StResp && status_q == StatusFull) |-> (n_q == CntW'(CAPACITY)))
  `ASSERT_PROP(a_count_commit, clk_i, rst_ni, (cnt_q != $past(cnt_q)) |-> ($past(state_q) == StResp))
  `ASSERT_NEVER(a_mem_clash, clk_i, rst_ni, rd_en && wr_en && (rd_addr == wr_addr))

endmodule

/* sim/testbench.sv */
`timescale 1ns / 100ps
// Testbench of the sorted table: a directed table of words, then random insert/remove/clear
// traffic checked against a behavioural copy of the table. Depends on stir_pkg,
// stir_req_if, stir_rsp_if and the top level sorted_table_insert_remove.
module testbench;
  import stir_pkg::*;

  localparam int CountWidth = $clog2(StirCapacity + 1);
  localparam logic [1:0] KindUnused = 2'd3;

  typedef logic signed [StirValueWidth-1:0] value_t;

  localparam value_t MaxValue = value_t'({1'b0, {(StirValueWidth - 1){1'b1}}});
  localparam value_t MinValue = value_t'({1'b1, {(StirValueWidth - 1){1'b0}}});

  typedef struct packed {
    status_e               status;
    logic [CountWidth-1:0] count;
    logic                  empty;
  } table_result_t;

  typedef struct packed {
    logic [1:0]    kind;
    value_t        value;
    bit            typed;
    table_result_t result;
  } directed_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  stir_req_if req_if ();
  stir_rsp_if rsp_if ();

  sorted_table_insert_remove dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  value_t          held_values[StirCapacity];
  int              held_count;
  table_result_t   expected_results[$];
  directed_row_t   directed_rows[$];
  int              failures;
  int              checked_words;
  bit              gaps_on;
  bit              stalls_on;
  bit              hold_request;

  function automatic table_result_t apply_table_op(input logic [1:0] kind, input value_t value);
    table_result_t res;
    int pos;
    int k;
    res.status = StatusOk;
    case (kind)
      KindInsert: begin
        if (held_count >= StirCapacity) begin
          res.status = StatusFull;
        end else begin
          pos = 0;
          while (pos < held_count && held_values[pos] < value) pos++;
          for (k = held_count; k > pos; k--) held_values[k] = held_values[k-1];
          held_values[pos] = value;
          held_count++;
        end
      end
      KindRemove: begin
        if (held_count == 0) begin
          res.status = StatusEmpty;
        end else begin
          pos = 0;
          while (pos < held_count && held_values[pos] != value) pos++;
          if (pos >= held_count) begin
            res.status = StatusNotFound;
          end else begin
            for (k = pos; k + 1 < held_count; k++) held_values[k] = held_values[k+1];
            held_count--;
          end
        end
      end
      KindClear: begin
        held_count = 0;
      end
      default: begin
      end
    endcase
    res.count = CountWidth'(held_count);
    res.empty = (held_count == 0);
    return res;
  endfunction

  task automatic add_row(input logic [1:0] kind, input value_t value, input bit typed = 1'b0,
                         input status_e status = StatusOk, input int count = 0,
                         input logic empty = 1'b0);
    directed_row_t row;
    row.kind   = kind;
    row.value  = value;
    row.typed  = typed;
    row.result = '{status, CountWidth'(count), empty};
    directed_rows.push_back(row);
  endtask

  // offer one word, hold it until taken, then predict its result
  task automatic send_word(input logic [1:0] kind, input value_t value, input bit typed,
                           input table_result_t typed_result);
    table_result_t predicted;
    while (gaps_on && $urandom_range(99) < 8) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.kind  <= kind;
    req_if.value <= value;
    do @(posedge clk_i); while (!req_if.ready);
    predicted = apply_table_op(kind, value);
    expected_results.push_back(typed ? typed_result : predicted);
  endtask

  task automatic random_traffic(input int words);
    int n;
    int insert_pct;
    int run_left;
    int pick;
    logic [1:0] kind;
    value_t value;
    insert_pct = 50;
    run_left = 0;
    for (n = 0; n < words; n++) begin
      // alternate filling and draining runs so that full and empty come round often
      if (run_left == 0) begin
        run_left = $urandom_range(60, 15);
        insert_pct = (insert_pct > 50) ? 25 : 80;
      end
      run_left--;
      pick = $urandom_range(99);
      if (pick < 3) kind = KindClear;
      else if (pick < 5) kind = KindUnused;
      else if ($urandom_range(99) < insert_pct) kind = KindInsert;
      else kind = KindRemove;
      pick = $urandom_range(99);
      if (kind == KindRemove && held_count != 0 && pick < 55) begin
        value = held_values[$urandom_range(held_count - 1)];
      end else if (pick < 70) begin
        value = int'($urandom_range(8)) - 4;
      end else if (pick < 80) begin
        case ($urandom_range(3))
          0: value = MinValue;
          1: value = MaxValue;
          2: value = MinValue + 1;
          default: value = MaxValue - 1;
        endcase
      end else begin
        value = $urandom;
      end
      send_word(kind, value, 1'b0, '0);
    end
  endtask

  task automatic check_result();
    table_result_t want;
    table_result_t got;
    got = '{rsp_if.status, rsp_if.entry_count, rsp_if.is_empty};
    checked_words++;
    if (expected_results.size() == 0) begin
      failures++;
      if (failures <= 10)
        $display("result word %0d arrived with nothing expected: status %0d count %0d empty %0d",
                 checked_words, got.status, got.count, got.empty);
    end else begin
      want = expected_results.pop_front();
      if (got.status !== want.status || got.count !== want.count || got.empty !== want.empty)
      begin
        failures++;
        if (failures <= 10)
          $display("result word %0d: expected status %0d count %0d empty %0d, got %0d %0d %0d",
                   checked_words, want.status, want.count, want.empty,
                   got.status, got.count, got.empty);
      end
    end
  endtask

  initial begin : response_sink
    int hold_cycles;
    hold_cycles = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && rsp_if.valid && rsp_if.ready) check_result();
      if (hold_request) begin
        hold_request = 1'b0;
        hold_cycles = 300;
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= !(stalls_on && $urandom_range(99) < 8);
      end
    end
  end

  initial begin : stimulus
    int i;
    req_if.valid = 1'b0;
    req_if.kind  = KindInsert;
    req_if.value = '0;
    held_count   = 0;
    failures     = 0;
    checked_words = 0;
    gaps_on      = 1'b1;
    stalls_on    = 1'b1;
    hold_request = 1'b0;

    add_row(KindRemove, 0, 1'b1, StatusEmpty, 0, 1'b1);
    add_row(KindClear, 0, 1'b1, StatusOk, 0, 1'b1);
    add_row(KindInsert, MinValue);
    add_row(KindInsert, MaxValue);
    add_row(KindInsert, 0);
    add_row(KindInsert, -1);
    add_row(KindInsert, 5);
    add_row(KindInsert, 5);
    add_row(KindInsert, 5);
    add_row(KindRemove, 5);
    add_row(KindRemove, 7, 1'b1, StatusNotFound, 6, 1'b0);
    add_row(KindUnused, -1);
    add_row(KindInsert, 32'sh5555_5555);
    add_row(KindInsert, 32'shAAAA_AAAA);
    add_row(KindInsert, 1);
    add_row(KindInsert, -2);
    add_row(KindInsert, 100);
    add_row(KindInsert, -100);
    add_row(KindInsert, 5);
    add_row(KindInsert, 0);
    add_row(KindInsert, 32'sh0000_FFFF);
    add_row(KindInsert, 32'shFFFF_0000);
    add_row(KindInsert, 3, 1'b1, StatusFull, 16, 1'b0);
    add_row(KindRemove, MaxValue);
    add_row(KindRemove, MinValue);
    add_row(KindClear, -1, 1'b1, StatusOk, 0, 1'b1);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < directed_rows.size(); i++)
      send_word(directed_rows[i].kind, directed_rows[i].value, directed_rows[i].typed,
                directed_rows[i].result);

    // hold off the receiver while words keep coming
    hold_request = 1'b1;
    random_traffic(250);

    // pause until every result is in
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (expected_results.size() != 0);

    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    random_traffic(200);
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    random_traffic(374);

    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (expected_results.size() != 0);
    repeat (40) @(posedge clk_i);

    if (failures == 0 && expected_results.size() == 0) begin
      $display("sorted_table_insert_remove: match");
    end else begin
      $display("sorted_table_insert_remove: mismatch");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("sorted_table_insert_remove: mismatch");
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/stir_pkg.sv
rtl/stir_chan_if.sv
rtl/sorted_table_insert_remove.sv
sim/testbench.sv
